[rtl/core/fcfl_pkg.sv]
package fcfl_pkg;

    // request actions
    typedef enum logic [1:0] {
        ACT_LOAD_DIR  = 2'd0,
        ACT_LOAD_LINK = 2'd1,
        ACT_LOOKUP    = 2'd2
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_END_OF_CHAIN = 2'd1,
        ST_NOT_FOUND    = 2'd2,
        ST_BAD_INDEX    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_SCAN = 3'd1,
        S_WALK = 3'd2,
        S_LINK = 3'd3,
        S_DONE = 3'd4
    } state_t;

    // outcome of comparing one name word
    typedef struct packed {
        logic mismatch;
        logic nul_match;
    } cmp_res_t;

    // link values at or above this end the chain
    localparam logic [15:0] CHAIN_END = 16'hFFF0;

    // directory entry layout
    localparam logic [1:0] WORD_START = 2'd0;
    localparam logic [1:0] WORD_NAME0 = 2'd1;

endpackage

[rtl/core/fcfl_req_if.sv]
interface fcfl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [10:0] index;
    logic [63:0] data;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [63:0] name_high;
    logic [15:0] block_offset;

    modport source (
        output valid, action, index, data, name_low, name_mid, name_high, block_offset,
        input  ready
    );
    modport sink (
        input  valid, action, index, data, name_low, name_mid, name_high, block_offset,
        output ready
    );
endinterface

[rtl/core/fcfl_resp_if.sv]
interface fcfl_resp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] block_number;

    modport source (
        output valid, status, block_number,
        input  ready
    );
    modport sink (
        input  valid, status, block_number,
        output ready
    );
endinterface

[rtl/core/fat_chain_file_locator.sv]
// loads (directory word or link entry) write when accepted and give no result
// lookup: reads directory words in order while scanning (up to 3 name words per entry,
//   plus the start word on a hit), then follows each link through the walk and link states,
//   checks the last step in the walk state and registers the result in the done state
// one request at a time; ready drops for the whole lookup
// rst_n clears control state; directory and link stores hold garbage until loaded
module fat_chain_file_locator #(
    parameter int DIR_ENTRIES  = 128,
    parameter int LINK_ENTRIES = 2048,
    parameter int NAME_BYTES   = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    fcfl_req_if.sink          req,
    fcfl_resp_if.source       resp
);

    localparam int DIR_WORDS  = DIR_ENTRIES * 4;
    localparam int EN_W       = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int DA_W       = EN_W + 2;
    localparam int LA_W       = $clog2(LINK_ENTRIES);
    localparam int NAME_WORDS = (NAME_BYTES + 7) / 8;
    localparam logic [1:0]      LAST_WORD  = 2'(NAME_WORDS);
    localparam logic [EN_W-1:0] LAST_ENTRY = EN_W'(DIR_ENTRIES - 1);

    fcfl_pkg::state_t  state_reg, state_next;
    logic [EN_W-1:0]   entry_reg, entry_next;
    logic [1:0]        word_reg, word_next;
    logic [63:0]       name_reg [3];
    logic [15:0]       steps_reg, steps_next;
    logic [15:0]       blk_reg, blk_next;
    fcfl_pkg::status_t status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [15:0]       out_block_reg, out_block_next;

    logic              req_fire;
    logic [31:0]       idx_ext;
    logic              dir_we, dir_re, link_we, link_re;
    logic [DA_W-1:0]   dir_raddr;
    logic [LA_W-1:0]   link_raddr;
    logic [63:0]       dir_rdata;
    logic [15:0]       link_rdata;
    logic [63:0]       req_word;
    logic [1:0]        word_sel;
    fcfl_pkg::cmp_res_t cmp;

    logic              scan_start, scan_hit, scan_miss, scan_last;
    logic              walk_done, walk_bad, link_end, out_free;

    assign req_fire = req.valid && req.ready;
    assign idx_ext  = 32'(req.index);
    assign out_free = !out_valid_reg || resp.ready;

    // load writes, ignored beyond the store
    assign dir_we  = req_fire && (req.action == fcfl_pkg::ACT_LOAD_DIR)
                     && (idx_ext < 32'(DIR_WORDS));
    assign link_we = req_fire && (req.action == fcfl_pkg::ACT_LOAD_LINK)
                     && (idx_ext < 32'(LINK_ENTRIES));

    fcfl_ram #(.WIDTH(64), .DEPTH(DIR_WORDS), .AW(DA_W)) u_dir (
        .clk   (clk),
        .we    (dir_we),
        .waddr (idx_ext[DA_W-1:0]),
        .wdata (req.data),
        .re    (dir_re),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    fcfl_ram #(.WIDTH(16), .DEPTH(LINK_ENTRIES), .AW(LA_W)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (idx_ext[LA_W-1:0]),
        .wdata (req.data[15:0]),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // request name word that lines up with the directory word just read
    assign word_sel = word_reg - 2'd1;
    always_comb
    begin
        case (word_reg)
            2'd1:    req_word = name_reg[0];
            2'd2:    req_word = name_reg[1];
            default: req_word = name_reg[2];
        endcase
    end

    fcfl_name_cmp #(.NAME_BYTES(NAME_BYTES)) u_cmp (
        .ent_word (dir_rdata),
        .req_word (req_word),
        .word_sel (word_sel),
        .res      (cmp)
    );

    // scan and walk decisions
    always_comb
    begin
        scan_start = (word_reg == fcfl_pkg::WORD_START);
        scan_hit   = !scan_start && cmp.nul_match;
        scan_miss  = !scan_start && !cmp.nul_match
                     && (cmp.mismatch || (word_reg == LAST_WORD));
        scan_last  = (entry_reg == LAST_ENTRY);
        walk_done  = (steps_reg == 16'd0);
        walk_bad   = (32'(blk_reg) >= 32'(LINK_ENTRIES));
        link_end   = (link_rdata >= fcfl_pkg::CHAIN_END);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcfl_pkg::S_IDLE:
            begin
                if (req_fire && (req.action == fcfl_pkg::ACT_LOOKUP))
                begin
                    state_next = fcfl_pkg::S_SCAN;
                end
            end
            fcfl_pkg::S_SCAN:
            begin
                if (scan_start)
                begin
                    state_next = fcfl_pkg::S_WALK;
                end
                else if (scan_miss && scan_last)
                begin
                    state_next = fcfl_pkg::S_DONE;
                end
            end
            fcfl_pkg::S_WALK:
            begin
                if (walk_done || walk_bad)
                begin
                    state_next = fcfl_pkg::S_DONE;
                end
                else
                begin
                    state_next = fcfl_pkg::S_LINK;
                end
            end
            fcfl_pkg::S_LINK:
            begin
                if (link_end)
                begin
                    state_next = fcfl_pkg::S_DONE;
                end
                else
                begin
                    state_next = fcfl_pkg::S_WALK;
                end
            end
            fcfl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = fcfl_pkg::S_IDLE;
                end
            end
            default: state_next = fcfl_pkg::S_IDLE;
        endcase
    end

    // datapath and memory reads
    always_comb
    begin
        entry_next      = entry_reg;
        word_next       = word_reg;
        steps_next      = steps_reg;
        blk_next        = blk_reg;
        status_next     = status_reg;
        dir_re          = 1'b0;
        dir_raddr       = {entry_reg, word_reg};
        link_re         = 1'b0;
        link_raddr      = blk_reg[LA_W-1:0];
        out_valid_next  = out_valid_reg && !resp.ready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        case (state_reg)
            fcfl_pkg::S_IDLE:
            begin
                if (req_fire && (req.action == fcfl_pkg::ACT_LOOKUP))
                begin
                    entry_next = '0;
                    word_next  = fcfl_pkg::WORD_NAME0;
                    steps_next = req.block_offset;
                    dir_re     = 1'b1;
                    dir_raddr  = {{EN_W{1'b0}}, fcfl_pkg::WORD_NAME0};
                end
            end
            fcfl_pkg::S_SCAN:
            begin
                if (scan_start)
                begin
                    blk_next = dir_rdata[15:0];
                end
                else if (scan_hit)
                begin
                    word_next = fcfl_pkg::WORD_START;
                    dir_re    = 1'b1;
                    dir_raddr = {entry_reg, fcfl_pkg::WORD_START};
                end
                else if (scan_miss)
                begin
                    if (scan_last)
                    begin
                        status_next = fcfl_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        entry_next = entry_reg + 1'b1;
                        word_next  = fcfl_pkg::WORD_NAME0;
                        dir_re     = 1'b1;
                        dir_raddr  = {entry_reg + 1'b1, fcfl_pkg::WORD_NAME0};
                    end
                end
                else
                begin
                    word_next = word_reg + 2'd1;
                    dir_re    = 1'b1;
                    dir_raddr = {entry_reg, word_reg + 2'd1};
                end
            end
            fcfl_pkg::S_WALK:
            begin
                if (walk_done)
                begin
                    status_next = fcfl_pkg::ST_OK;
                end
                else if (walk_bad)
                begin
                    status_next = fcfl_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    link_re = 1'b1;
                end
            end
            fcfl_pkg::S_LINK:
            begin
                if (link_end)
                begin
                    status_next = fcfl_pkg::ST_END_OF_CHAIN;
                end
                else
                begin
                    blk_next   = link_rdata;
                    steps_next = steps_reg - 16'd1;
                end
            end
            fcfl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_block_next  = (status_reg == fcfl_pkg::ST_OK) ? blk_reg : 16'd0;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcfl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        word_reg       <= word_next;
        steps_reg      <= steps_next;
        blk_reg        <= blk_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        if (req_fire && (req.action == fcfl_pkg::ACT_LOOKUP))
        begin
            name_reg[0] <= req.name_low;
            name_reg[1] <= req.name_mid;
            name_reg[2] <= req.name_high;
        end
    end

    assign req.ready         = (state_reg == fcfl_pkg::S_IDLE);
    assign resp.valid        = out_valid_reg;
    assign resp.status       = out_status_reg;
    assign resp.block_number = out_block_reg;

endmodule

[rtl/core/fcfl_ram.sv]
module fcfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fcfl_name_cmp.sv]
module fcfl_name_cmp #(
    parameter int NAME_BYTES = 24
) (
    input  logic [63:0]        ent_word,
    input  logic [63:0]        req_word,
    input  logic [1:0]         word_sel,
    output fcfl_pkg::cmp_res_t res
);

    // first byte of this word that decides the match, in name order
    always_comb
    begin
        logic found;
        found = 1'b0;
        res   = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (!found && ((int'(word_sel) * 8 + j) < NAME_BYTES))
            begin
                if (ent_word[8*j +: 8] != req_word[8*j +: 8])
                begin
                    res.mismatch = 1'b1;
                    found        = 1'b1;
                end
                else if (ent_word[8*j +: 8] == 8'h00)
                begin
                    res.nul_match = 1'b1;
                    found         = 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/fcfl_chk.sv]
module fcfl_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_action,
    input logic        resp_valid,
    input logic        resp_ready,
    input logic [1:0]  resp_status,
    input logic [15:0] resp_block_number
);

    // a stalled result holds
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=>
            resp_valid && $stable(resp_status) && $stable(resp_block_number))
        else $error("result changed while stalled");

    // a lookup request makes the block busy
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == fcfl_pkg::ACT_LOOKUP) |=> !req_ready)
        else $error("ready after lookup request");

    // a load or unused request never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action != fcfl_pkg::ACT_LOOKUP) && !resp_valid
            |=> !resp_valid)
        else $error("result after load request");

    // a new result only comes out of a busy lookup
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid) |-> !$past(req_ready))
        else $error("result appeared while idle");

    // block number is zero unless status is ok
    a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && (resp_status != fcfl_pkg::ST_OK) |-> (resp_block_number == 16'd0))
        else $error("nonzero block number on failed lookup");

endmodule

bind fat_chain_file_locator fcfl_chk u_fcfl_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_action        (req.action),
    .resp_valid        (resp.valid),
    .resp_ready        (resp.ready),
    .resp_status       (resp.status),
    .resp_block_number (resp.block_number)
);

[tb/sv/fat_chain_file_locator_tb.sv]
module fat_chain_file_locator_tb;

    localparam int DIR_ENTRIES   = 128;
    localparam int DIR_WORDS     = DIR_ENTRIES * 4;
    localparam int LINK_ENTRIES  = 2048;
    localparam int NAME_BYTES    = 24;
    localparam int MAX_GAP       = 17;
    localparam int LOOP_BLOCKS   = 16;
    localparam int LINK_USED     = 256;
    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 4 * DIR_ENTRIES + 64;
    localparam int LONG_HOLD     = 400;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        fcfl_pkg::status_t status;
        logic [15:0]       block;
    } locate_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fcfl_req_if  req_bus ();
    fcfl_resp_if resp_bus ();

    fat_chain_file_locator #(
        .DIR_ENTRIES  (DIR_ENTRIES),
        .LINK_ENTRIES (LINK_ENTRIES),
        .NAME_BYTES   (NAME_BYTES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .resp  (resp_bus)
    );

    // shadow copies of the directory and the link table
    logic [63:0] dir_shadow [DIR_WORDS];
    logic [15:0] link_shadow [LINK_ENTRIES];

    locate_result_t pending_locates [$];
    int failure_count = 0;
    int sent_count    = 0;
    bit sender_quiet  = 1'b0;
    int hold_request  = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [191:0] noise_bits();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [191:0] entry_name(int e);
        return {dir_shadow[4 * e + 3], dir_shadow[4 * e + 2], dir_shadow[4 * e + 1]};
    endfunction

    // position of the first nul, or NAME_BYTES when there is none
    function automatic int name_length(logic [191:0] name);
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            if (name[8 * k +: 8] == 8'h00)
                return k;
        end
        return NAME_BYTES;
    endfunction

    // equal up to a shared nul; no nul on either side means no match
    function automatic bit names_match(logic [191:0] wanted, logic [191:0] stored);
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            if (stored[8 * k +: 8] != wanted[8 * k +: 8])
                return 1'b0;
            if (stored[8 * k +: 8] == 8'h00)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // first matching entry, then follow the chain offset times
    function automatic locate_result_t locate_block(logic [191:0] wanted, logic [15:0] offset);
        locate_result_t res;
        logic [15:0] blk;
        int steps;
        res.status = fcfl_pkg::ST_NOT_FOUND;
        res.block  = 16'd0;
        steps = offset;
        for (int e = 0; e < DIR_ENTRIES; e++)
        begin
            if (names_match(wanted, entry_name(e)))
            begin
                blk = dir_shadow[4 * e][15:0];
                for (int s = 0; s < steps; s++)
                begin
                    if (blk >= LINK_ENTRIES)
                    begin
                        res.status = fcfl_pkg::ST_BAD_INDEX;
                        return res;
                    end
                    blk = link_shadow[blk];
                    if (blk >= fcfl_pkg::CHAIN_END)
                    begin
                        res.status = fcfl_pkg::ST_END_OF_CHAIN;
                        return res;
                    end
                end
                res.status = fcfl_pkg::ST_OK;
                res.block  = blk;
                return res;
            end
        end
        return res;
    endfunction

    // name of len characters, nul after them, junk beyond
    function automatic logic [191:0] make_name(int len);
        logic [191:0] name;
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            if (k < len)
                name[8 * k +: 8] = ($urandom_range(0, 1) == 0) ?
                    8'(8'h41 + $urandom_range(0, 3)) : 8'($urandom_range(1, 255));
            else if (k == len)
                name[8 * k +: 8] = 8'h00;
            else
                name[8 * k +: 8] = 8'($urandom_range(0, 255));
        end
        return name;
    endfunction

    function automatic logic [191:0] random_name(int known_entries);
        logic [191:0] name;
        int pick;
        int len;
        int p;
        pick = $urandom_range(0, 99);
        if (known_entries > 0 && pick < 30)
        begin
            // variant of a stored name, sharing a prefix with it
            name = entry_name($urandom_range(0, known_entries - 1));
            len = name_length(name);
            if (len == 0)
                return make_name(1);
            p = $urandom_range(0, len - 1);
            if (pick < 15)
                name[8 * p +: 8] = 8'h00;
            else
                name[8 * p +: 8] = (name[8 * p +: 8] == 8'hFF) ? 8'h01 : name[8 * p +: 8] + 8'h01;
            return name;
        end
        if (pick < 40)
            len = 0;
        else if (pick < 50)
            len = NAME_BYTES - 1;
        else if (pick < 55)
            len = NAME_BYTES;
        else
            len = $urandom_range(1, NAME_BYTES - 2);
        return make_name(len);
    endfunction

    // stored name with fresh junk after the nul
    function automatic logic [191:0] lookup_name_for(int e);
        logic [191:0] name;
        int len;
        name = entry_name(e);
        len = name_length(name);
        for (int k = len + 1; k < NAME_BYTES; k++)
            name[8 * k +: 8] = 8'($urandom_range(0, 255));
        return name;
    endfunction

    function automatic logic [191:0] random_lookup_name();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return lookup_name_for($urandom_range(0, DIR_ENTRIES - 1));
        if (pick < 87)
            return random_name(DIR_ENTRIES);
        return noise_bits();
    endfunction

    // links only point into the loaded low part of the table, the top entry or past the table
    function automatic logic [15:0] random_link_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 16'($urandom_range(0, LINK_USED - 1));
        if (pick < 82)
            return 16'($urandom_range(16'hFFF0, 16'hFFFF));
        if (pick < 94)
            return 16'($urandom_range(LINK_ENTRIES, 16'hFFEF));
        case ($urandom_range(0, 3))
            0: return 16'(LINK_ENTRIES - 1);
            1: return 16'(LINK_ENTRIES);
            2: return 16'hFFEF;
            default: return fcfl_pkg::CHAIN_END;
        endcase
    endfunction

    function automatic logic [15:0] random_start();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return 16'($urandom_range(0, LINK_USED - 1));
        if (pick < 85)
            return 16'($urandom_range(0, LOOP_BLOCKS - 1));
        if (pick < 93)
            return 16'($urandom_range(LINK_ENTRIES, 16'hFFFF));
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'(LINK_ENTRIES - 1);
            2: return 16'(LINK_ENTRIES);
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] random_offset();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 16'($urandom_range(0, 3));
        if (pick < 80)
            return 16'($urandom_range(4, 24));
        if (pick < 97)
            return 16'($urandom_range(25, 300));
        return 16'($urandom_range(301, 1000));
    endfunction

    // ring of blocks at the bottom, a few fixed edge-case links, the rest random
    function automatic logic [15:0] seed_link(int i);
        if (i < LOOP_BLOCKS)
            return 16'((i + 1) % LOOP_BLOCKS);
        case (i)
            16: return 16'd17;
            17: return fcfl_pkg::CHAIN_END;
            18: return 16'hFFEF;
            19: return 16'(LINK_ENTRIES - 1);
            20: return 16'(LINK_ENTRIES);
            21: return 16'd0;
            LINK_ENTRIES - 1: return 16'hFFFF;
            default: return random_link_value();
        endcase
    endfunction

    task automatic log_failure(string msg);
        failure_count++;
        if (failure_count <= 10)
            $display("%s", msg);
    endtask

    // offer one request, wait for it to be taken, then update the shadow state
    task automatic send_request(logic [1:0] action, logic [10:0] index, logic [63:0] data,
                                logic [191:0] name, logic [15:0] offset);
        int gap;
        if (sent_count % 40 == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
        sent_count++;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.action       <= action;
        req_bus.index        <= index;
        req_bus.data         <= data;
        req_bus.name_low     <= name[63:0];
        req_bus.name_mid     <= name[127:64];
        req_bus.name_high    <= name[191:128];
        req_bus.block_offset <= offset;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        case (action)
            fcfl_pkg::ACT_LOAD_DIR:
            begin
                if (index < DIR_WORDS)
                    dir_shadow[index] = data;
            end
            fcfl_pkg::ACT_LOAD_LINK:
            begin
                if (index < LINK_ENTRIES)
                    link_shadow[index] = data[15:0];
            end
            fcfl_pkg::ACT_LOOKUP: pending_locates.push_back(locate_block(name, offset));
            default: ;
        endcase
    endtask

    task automatic lookup(logic [191:0] name, logic [15:0] offset);
        send_request(fcfl_pkg::ACT_LOOKUP, 11'($urandom), {$urandom, $urandom}, name, offset);
    endtask

    task automatic load_entry(int e, logic [191:0] name, logic [15:0] start);
        send_request(fcfl_pkg::ACT_LOAD_DIR, 11'(4 * e), {$urandom, 16'($urandom), start},
                     noise_bits(), 16'($urandom));
        for (int w = 1; w < 4; w++)
            send_request(fcfl_pkg::ACT_LOAD_DIR, 11'(4 * e + w), name[64 * (w - 1) +: 64],
                         noise_bits(), 16'($urandom));
    endtask

    // stop offering and wait for every outstanding lookup to answer
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_locates.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // low part of the link table, its top entry and every directory word get written
    task automatic test_fill_stores();
        for (int i = 0; i < LINK_USED; i++)
            send_request(fcfl_pkg::ACT_LOAD_LINK, 11'(i),
                         {$urandom, 16'($urandom), seed_link(i)},
                         noise_bits(), 16'($urandom));
        send_request(fcfl_pkg::ACT_LOAD_LINK, 11'(LINK_ENTRIES - 1),
                     {$urandom, 16'($urandom), seed_link(LINK_ENTRIES - 1)},
                     noise_bits(), 16'($urandom));
        for (int e = 0; e < DIR_ENTRIES; e++)
        begin
            case (e)
                0: load_entry(e, make_name(0), 16'd16);
                1: load_entry(e, make_name(NAME_BYTES - 1), 16'd0);
                2: load_entry(e, make_name(NAME_BYTES), 16'd21);
                4: load_entry(e, make_name(5), 16'hFFFF);
                5: load_entry(e, make_name(3), 16'd19);
                6: load_entry(e, make_name(6), 16'(LINK_ENTRIES));
                7: load_entry(e, make_name(8), 16'd18);
                8: load_entry(e, make_name(16), 16'(LINK_ENTRIES - 1));
                // duplicate of entry 5, must lose to it
                9: load_entry(e, lookup_name_for(5), 16'd20);
                DIR_ENTRIES - 1: load_entry(e, make_name(12), 16'd17);
                default: load_entry(e, random_name(e), random_start());
            endcase
        end
    endtask

    task automatic test_directed_lookups();
        logic [191:0] prefix;
        // empty name, then its chain to the end marker
        lookup(lookup_name_for(0), 16'd0);
        lookup('0, 16'd1);
        lookup(lookup_name_for(0), 16'd2);
        // longest name, then a full-range walk around the ring
        lookup(lookup_name_for(1), 16'd0);
        lookup(lookup_name_for(1), 16'hFFFF);
        lookup(lookup_name_for(1), 16'd16);
        // stored name without nul never matches; a duplicate name finds the first entry
        lookup(lookup_name_for(2), 16'd0);
        lookup(lookup_name_for(5), 16'd1);
        lookup(lookup_name_for(9), 16'd2);
        // start block out of the table
        lookup(lookup_name_for(4), 16'd0);
        lookup(lookup_name_for(4), 16'd1);
        lookup(lookup_name_for(6), 16'hFFFF);
        // names ending on a word boundary and inside a word, a name with no nul, a cut-short prefix
        lookup(lookup_name_for(7), 16'd1);
        lookup(lookup_name_for(7), 16'd2);
        lookup(lookup_name_for(8), 16'd1);
        lookup(lookup_name_for(DIR_ENTRIES - 1), 16'd0);
        lookup({192{1'b1}}, 16'd3);
        prefix = entry_name(1);
        prefix[71:64] = 8'h00;
        lookup(prefix, 16'd0);
        // ignored requests, then a rewrite of the top link entry with its own value
        send_request(ACT_UNUSED, '1, '1, '1, '1);
        send_request(fcfl_pkg::ACT_LOAD_DIR, 11'd2047, '1, '1, '1);
        send_request(fcfl_pkg::ACT_LOAD_DIR, 11'(DIR_WORDS), '0, '0, '0);
        send_request(fcfl_pkg::ACT_LOAD_LINK, 11'(LINK_ENTRIES - 1), '1, '0, '0);
        lookup(lookup_name_for(8), 16'd1);
    endtask

    // receiver holds off while lookups keep coming, so the block backs up
    task automatic test_output_backpressure();
        drain_results();
        hold_request = LONG_HOLD;
        for (int i = 0; i < 8; i++)
            lookup(lookup_name_for($urandom_range(0, DIR_ENTRIES - 1)),
                   16'($urandom_range(0, 8)));
    endtask

    task automatic test_random_traffic();
        int counted;
        int since_pause;
        int pick;
        counted = 0;
        since_pause = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                lookup(random_lookup_name(), random_offset());
                counted++;
            end
            else if (pick < 74)
            begin
                load_entry($urandom_range(0, DIR_ENTRIES - 1), random_name(DIR_ENTRIES),
                           random_start());
                counted += 4;
            end
            else if (pick < 80)
            begin
                send_request(fcfl_pkg::ACT_LOAD_DIR, 11'($urandom_range(0, DIR_WORDS - 1)),
                             {$urandom, $urandom}, noise_bits(), 16'($urandom));
                counted++;
            end
            else if (pick < 95)
            begin
                // the ring at the bottom of the table stays intact
                send_request(fcfl_pkg::ACT_LOAD_LINK,
                             11'($urandom_range(LOOP_BLOCKS, LINK_ENTRIES - 1)),
                             {$urandom, 16'($urandom), random_link_value()},
                             noise_bits(), 16'($urandom));
                counted++;
            end
            else if (pick < 97)
                send_request(ACT_UNUSED, 11'($urandom), {$urandom, $urandom}, noise_bits(),
                             16'($urandom));
            else
                send_request(fcfl_pkg::ACT_LOAD_DIR, 11'($urandom_range(DIR_WORDS, 2047)),
                             {$urandom, $urandom}, noise_bits(), 16'($urandom));
            since_pause++;
            if (since_pause >= 200)
            begin
                drain_results();
                since_pause = 0;
            end
        end
    endtask

    // result side: random stalls, compare against the oldest prediction
    initial
    begin : result_checker
        int stall;
        int taken;
        bit rx_quiet;
        locate_result_t want;
        resp_bus.ready <= 1'b0;
        taken = 0;
        rx_quiet = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                resp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            resp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!resp_bus.valid)
                @(posedge clk);
            taken++;
            if (pending_locates.size() == 0)
                log_failure($sformatf("unexpected result: status %0d block 0x%04h",
                                      resp_bus.status, resp_bus.block_number));
            else
            begin
                want = pending_locates.pop_front();
                if (resp_bus.status !== want.status || resp_bus.block_number !== want.block)
                    log_failure($sformatf(
                        "result %0d: status exp %0d got %0d, block exp 0x%04h got 0x%04h",
                        taken, want.status, resp_bus.status, want.block,
                        resp_bus.block_number));
            end
        end
    end

    // stimulus
    initial
    begin
        req_bus.valid        <= 1'b0;
        req_bus.action       <= fcfl_pkg::ACT_LOAD_DIR;
        req_bus.index        <= '0;
        req_bus.data         <= '0;
        req_bus.name_low     <= '0;
        req_bus.name_mid     <= '0;
        req_bus.name_high    <= '0;
        req_bus.block_offset <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_stores();
        test_directed_lookups();
        test_output_backpressure();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failure_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #250_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
